### hw/rtl/egcd_pkg.sv
// Shared constants, widths and sequencer states for the extended gcd core.
// No dependencies; compile this file first.
package egcd_pkg;

  localparam int OPERAND_WIDTH = 31;
  localparam int COEF_WIDTH    = OPERAND_WIDTH + 1;
  localparam int CNT_W         = $clog2(OPERAND_WIDTH);

  // Fixed field widths of the channels
  localparam int IN_FIELD_W   = 31;
  localparam int GCD_FIELD_W  = 31;
  localparam int COEF_FIELD_W = 32;
  localparam int INV_FIELD_W  = 31;

  typedef logic [OPERAND_WIDTH-1:0]      operand_t;
  typedef logic signed [COEF_WIDTH-1:0]  coef_t;
  typedef logic [CNT_W-1:0]              cnt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPD,
    ST_FIN
  } egcd_state_t;

endpackage

### hw/rtl/egcd_in_if.sv
// Input channel: operand pair with valid/ready handshake.
// Depends on egcd_pkg.
interface egcd_in_if;
  import egcd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [IN_FIELD_W-1:0] first_operand;
  logic [IN_FIELD_W-1:0] second_operand;

  modport source (output valid, output first_operand, output second_operand, input ready);
  modport sink   (input valid, input first_operand, input second_operand, output ready);
endinterface

### hw/rtl/egcd_out_if.sv
// Result channel: gcd, Bezout coefficients and modular inverse with valid/ready.
// Depends on egcd_pkg.
interface egcd_out_if;
  import egcd_pkg::*;

  logic                           valid;
  logic                           ready;
  logic [GCD_FIELD_W-1:0]         gcd_value;
  logic signed [COEF_FIELD_W-1:0] coef_first;
  logic signed [COEF_FIELD_W-1:0] coef_second;
  logic [INV_FIELD_W-1:0]         inverse_value;
  logic                           inverse_valid;

  modport source (output valid, output gcd_value, output coef_first, output coef_second,
                  output inverse_value, output inverse_valid, input ready);
  modport sink   (input valid, input gcd_value, input coef_first, input coef_second,
                  input inverse_value, input inverse_valid, output ready);
endinterface

### hw/rtl/extended_gcd_modular_inverse_core.sv
// Extended Euclidean algorithm core: gcd, Bezout coefficients, modular inverse.
// Depends on egcd_pkg, egcd_in_if and egcd_out_if.
//
// One operand pair is taken at a time; in_ch.ready is high only while the
// sequencer is idle. Each Euclid round runs a check state, then a restoring
// divider at one quotient bit per cycle that folds the quotient into both
// coefficient updates in the same cycles, then an update state. There is
// one round per division step: none when the second operand is zero, at
// most 45 for 31-bit operands. The result becomes valid in the same cycle
// that in_ch.ready comes back, so a new pair is taken only once the sequencer
// has finished the previous one.
// The result sits in an output register, so the next pair is taken while an
// earlier result still waits for out_ch.ready; a result that is ready while
// the register is still full holds the sequencer until that transfer.
module extended_gcd_modular_inverse_core (
  input  logic             clk,
  input  logic             rst_n,
  egcd_in_if.sink          in_ch,
  egcd_out_if.source       out_ch
);
  import egcd_pkg::*;

  egcd_state_t state_r, state_nxt;

  operand_t a_r, a_nxt;          // dividend of the current round
  operand_t b_r, b_nxt;          // divisor of the current round
  operand_t mod_r, mod_nxt;      // modulus kept for the inverse
  operand_t rem_r, rem_nxt;      // partial remainder
  operand_t div_r, div_nxt;      // dividend bits still to shift in
  cnt_t     cnt_r, cnt_nxt;
  coef_t    s_prev_r, s_prev_nxt, s_cur_r, s_cur_nxt, s_acc_r, s_acc_nxt;
  coef_t    t_prev_r, t_prev_nxt, t_cur_r, t_cur_nxt, t_acc_r, t_acc_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [GCD_FIELD_W-1:0]         gcd_r, gcd_nxt;
  logic signed [COEF_FIELD_W-1:0] cf_r, cf_nxt, cs_r, cs_nxt;
  logic [INV_FIELD_W-1:0]         inv_r, inv_nxt;
  logic                           invv_r, invv_nxt;

  logic [OPERAND_WIDTH:0] trial;
  logic                   q_bit;
  coef_t                  mod_ext;
  coef_t                  inv_full;
  logic                   inv_ok;

  // One restoring divider step
  always_comb begin
    trial = {rem_r, div_r[OPERAND_WIDTH-1]};
    q_bit = (trial >= {1'b0, b_r});
  end

  // Bring t into [0, modulus); |t| never exceeds the modulus here
  always_comb begin
    mod_ext = coef_t'(mod_r);
    if (t_prev_r[COEF_WIDTH-1]) begin
      inv_full = t_prev_r + mod_ext;
    end else if (t_prev_r >= mod_ext) begin
      inv_full = t_prev_r - mod_ext;
    end else begin
      inv_full = t_prev_r;
    end
    inv_ok = (a_r == operand_t'(1)) && (mod_r != '0);
  end

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    mod_nxt       = mod_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    cnt_nxt       = cnt_r;
    s_prev_nxt    = s_prev_r;
    s_cur_nxt     = s_cur_r;
    s_acc_nxt     = s_acc_r;
    t_prev_nxt    = t_prev_r;
    t_cur_nxt     = t_cur_r;
    t_acc_nxt     = t_acc_r;
    gcd_nxt       = gcd_r;
    cf_nxt        = cf_r;
    cs_nxt        = cs_r;
    inv_nxt       = inv_r;
    invv_nxt      = invv_r;
    out_valid_nxt = out_valid_r;

    // drop the result once it transfers
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          a_nxt      = operand_t'(in_ch.first_operand);
          b_nxt      = operand_t'(in_ch.second_operand);
          mod_nxt    = operand_t'(in_ch.first_operand);
          s_prev_nxt = coef_t'(1);
          s_cur_nxt  = '0;
          t_prev_nxt = '0;
          t_cur_nxt  = coef_t'(1);
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (b_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          rem_nxt   = '0;
          div_nxt   = a_r;
          cnt_nxt   = cnt_t'(OPERAND_WIDTH - 1);
          s_acc_nxt = '0;
          t_acc_nxt = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // quotient bits arrive MSB first: accumulate q*s and q*t by Horner
        rem_nxt   = q_bit ? operand_t'(trial - {1'b0, b_r}) : operand_t'(trial);
        div_nxt   = {div_r[OPERAND_WIDTH-2:0], 1'b0};
        s_acc_nxt = (s_acc_r <<< 1) + (q_bit ? s_cur_r : coef_t'(0));
        t_acc_nxt = (t_acc_r <<< 1) + (q_bit ? t_cur_r : coef_t'(0));
        cnt_nxt   = cnt_r - cnt_t'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        a_nxt      = b_r;
        b_nxt      = rem_r;
        s_prev_nxt = s_cur_r;
        s_cur_nxt  = s_prev_r - s_acc_r;
        t_prev_nxt = t_cur_r;
        t_cur_nxt  = t_prev_r - t_acc_r;
        state_nxt  = ST_CHECK;
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          gcd_nxt       = GCD_FIELD_W'(a_r);
          cf_nxt        = COEF_FIELD_W'(s_prev_r);
          cs_nxt        = COEF_FIELD_W'(t_prev_r);
          inv_nxt       = inv_ok ? INV_FIELD_W'(inv_full) : '0;
          invv_nxt      = inv_ok;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    mod_r    <= mod_nxt;
    rem_r    <= rem_nxt;
    div_r    <= div_nxt;
    cnt_r    <= cnt_nxt;
    s_prev_r <= s_prev_nxt;
    s_cur_r  <= s_cur_nxt;
    s_acc_r  <= s_acc_nxt;
    t_prev_r <= t_prev_nxt;
    t_cur_r  <= t_cur_nxt;
    t_acc_r  <= t_acc_nxt;
    gcd_r    <= gcd_nxt;
    cf_r     <= cf_nxt;
    cs_r     <= cs_nxt;
    inv_r    <= inv_nxt;
    invv_r   <= invv_nxt;
  end

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.gcd_value     = gcd_r;
  assign out_ch.coef_first    = cf_r;
  assign out_ch.coef_second   = cs_r;
  assign out_ch.inverse_value = inv_r;
  assign out_ch.inverse_valid = invv_r;

endmodule

### hw/rtl/egcd_checker.sv
// Port-level checker for the extended gcd core, attached by bind.
// Depends on egcd_pkg and extended_gcd_modular_inverse_core.
module egcd_checker (
  input logic                                     clk,
  input logic                                     rst_n,
  input logic                                     in_valid,
  input logic                                     in_ready,
  input logic                                     out_valid,
  input logic                                     out_ready,
  input logic [egcd_pkg::GCD_FIELD_W-1:0]         gcd_value,
  input logic signed [egcd_pkg::COEF_FIELD_W-1:0] coef_first,
  input logic signed [egcd_pkg::COEF_FIELD_W-1:0] coef_second,
  input logic [egcd_pkg::INV_FIELD_W-1:0]         inverse_value,
  input logic                                     inverse_valid
);
  import egcd_pkg::*;

  // the core is busy right after it takes a pair
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("core ready right after input transfer");

  a_inv_needs_gcd_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && inverse_valid) |-> (gcd_value == GCD_FIELD_W'(1)))
    else $error("inverse flagged valid with gcd other than one");

  a_inv_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !inverse_valid) |-> (inverse_value == '0))
    else $error("nonzero inverse with invalid flag");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(gcd_value) && $stable(coef_first)
      && $stable(coef_second) && $stable(inverse_value) && $stable(inverse_valid)))
    else $error("stalled result changed or dropped");

endmodule

bind extended_gcd_modular_inverse_core egcd_checker u_egcd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .gcd_value     (out_ch.gcd_value),
  .coef_first    (out_ch.coef_first),
  .coef_second   (out_ch.coef_second),
  .inverse_value (out_ch.inverse_value),
  .inverse_valid (out_ch.inverse_valid)
);

### verif/tb_extended_gcd_modular_inverse_core.sv
// Self-checking testbench for the extended gcd / modular inverse core.
// Needs egcd_pkg, egcd_in_if, egcd_out_if and the core; compares every transfer against
// a behavioral Euclid predictor or fixed values under random source gaps and sink stalls.
module tb_extended_gcd_modular_inverse_core;
  timeunit 1ns;
  timeprecision 1ps;

  import egcd_pkg::*;

  localparam operand_t OP_MAX      = '1;
  localparam int       NUM_DIR     = 23;
  localparam int       NUM_RANDOM  = 400;
  localparam int       DRAIN_CYCLES = 2000;

  typedef struct packed {
    logic [GCD_FIELD_W-1:0]         gcd_value;
    logic signed [COEF_FIELD_W-1:0] coef_first;
    logic signed [COEF_FIELD_W-1:0] coef_second;
    logic [INV_FIELD_W-1:0]         inverse_value;
    logic                           inverse_valid;
  } bezout_t;

  typedef struct {
    operand_t first_operand;
    operand_t second_operand;
    bit       has_fixed;
    bezout_t  fixed_result;
  } dir_row_t;

  logic clk;
  logic rst_n;

  egcd_in_if  in_ch ();
  egcd_out_if out_ch ();

  extended_gcd_modular_inverse_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bezout_t pending_results [$];
  int      mismatch_count = 0;
  int      burst_left = 0;

  // Expected values are typed in only for the trivial rows.
  dir_row_t dir_rows [NUM_DIR] = '{
    '{31'd0,          31'd0,          1'b1, '{31'd0, 32'sd1, 32'sd0, 31'd0, 1'b0}},
    '{31'd0,          31'd5,          1'b1, '{31'd5, 32'sd0, 32'sd1, 31'd0, 1'b0}},
    '{31'd0,          31'd1,          1'b1, '{31'd1, 32'sd0, 32'sd1, 31'd0, 1'b0}},
    '{31'd7,          31'd0,          1'b1, '{31'd7, 32'sd1, 32'sd0, 31'd0, 1'b0}},
    '{31'd1,          31'd0,          1'b1, '{31'd1, 32'sd1, 32'sd0, 31'd0, 1'b1}},
    '{31'd1,          31'd1,          1'b1, '{31'd1, 32'sd0, 32'sd1, 31'd0, 1'b1}},
    '{31'd1,          31'd12345,      1'b0, '0},
    '{OP_MAX,         OP_MAX,         1'b1, '{OP_MAX, 32'sd0, 32'sd1, 31'd0, 1'b0}},
    '{OP_MAX,         31'd0,          1'b1, '{OP_MAX, 32'sd1, 32'sd0, 31'd0, 1'b0}},
    '{31'd0,          OP_MAX,         1'b1, '{OP_MAX, 32'sd0, 32'sd1, 31'd0, 1'b0}},
    '{OP_MAX,         31'd1,          1'b1, '{31'd1, 32'sd0, 32'sd1, 31'd1, 1'b1}},
    '{OP_MAX,         OP_MAX - 31'd1, 1'b0, '0},
    '{OP_MAX - 31'd1, OP_MAX,         1'b0, '0},
    '{31'd1836311903, 31'd1134903170, 1'b0, '0},
    '{31'd1134903170, 31'd1836311903, 1'b0, '0},
    '{31'd3120,       31'd17,         1'b0, '0},
    '{31'd26,         31'd7,          1'b0, '0},
    '{31'd240,        31'd46,         1'b0, '0},
    '{31'h55555555,   31'h2AAAAAAA,   1'b0, '0},
    '{31'h2AAAAAAA,   31'h55555555,   1'b0, '0},
    '{OP_MAX,         31'd123456789,  1'b0, '0},
    '{31'd4096,       31'd2048,       1'b0, '0},
    '{31'd2,          OP_MAX,         1'b0, '0}
  };

  function automatic bezout_t predict_bezout(operand_t x, operand_t y);
    longint unsigned a, b, modulus, q, r;
    longint unsigned s_prev, s_cur, t_prev, t_cur, s_next, t_next, rem, inv;
    bit              has_inverse;
    bezout_t         res;
    a = x;
    b = y;
    modulus = a;
    s_prev = 1; s_cur = 0;
    t_prev = 0; t_cur = 1;
    inv = 0;
    while (b != 0) begin
      q = a / b;
      r = a - q * b;
      s_next = s_prev - q * s_cur;
      t_next = t_prev - q * t_cur;
      a = b;
      b = r;
      s_prev = s_cur;
      s_cur  = s_next;
      t_prev = t_cur;
      t_cur  = t_next;
    end
    has_inverse = (a == 1) && (modulus != 0);
    if (has_inverse) begin
      // Fold a negative coefficient back into [0, modulus).
      if (t_prev[63]) begin
        rem = (64'd0 - t_prev) % modulus;
        inv = (rem != 0) ? modulus - rem : 0;
      end else begin
        inv = t_prev % modulus;
      end
    end
    res.gcd_value     = a[GCD_FIELD_W-1:0];
    res.coef_first    = s_prev[COEF_FIELD_W-1:0];
    res.coef_second   = t_prev[COEF_FIELD_W-1:0];
    res.inverse_value = has_inverse ? inv[INV_FIELD_W-1:0] : '0;
    res.inverse_valid = has_inverse;
    return res;
  endfunction

  function automatic operand_t random_operand(int unsigned shape);
    int unsigned g, w;
    operand_t    v;
    case (shape)
      0, 1, 2, 3: v = operand_t'($urandom());
      4, 5:       v = operand_t'($urandom_range(0, 255));
      6: begin
        g = $urandom_range(2, 1000);
        v = operand_t'(g * $urandom_range(0, 32'h7FFFFFFF / g));
      end
      7: begin
        case ($urandom_range(0, 2))
          0:       v = '0;
          1:       v = operand_t'(1);
          default: v = OP_MAX;
        endcase
      end
      default: begin
        w = $urandom_range(1, 31);
        v = operand_t'($urandom() & ((32'd1 << w) - 1));
      end
    endcase
    return v;
  endfunction

  // Present one operand pair, honoring the burst/gap pattern, and hold it until transfer.
  task automatic send_pair(operand_t x, operand_t y, bit has_fixed, bezout_t fixed_result);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_ch.valid          = 1'b1;
    in_ch.first_operand  = x;
    in_ch.second_operand = y;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.insert(pending_results.size(),
                           has_fixed ? fixed_result : predict_bezout(x, y));
    burst_left--;
  endtask

  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    #30_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int       shape;
    operand_t x, y;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.first_operand  = '0;
    in_ch.second_operand = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      send_pair(dir_rows[i].first_operand, dir_rows[i].second_operand,
                dir_rows[i].has_fixed, dir_rows[i].fixed_result);
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      shape = $urandom_range(0, 9);
      x = random_operand(shape);
      y = random_operand(($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : shape);
      send_pair(x, y, 1'b0, '0);
    end

    @(negedge clk);
    in_ch.valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    // Stay a while longer to catch any spurious transfer.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Sink: switch among always-ready, coin-flip and periodic stall patterns.
  initial begin : sink_stall
    int mode, run_len, period, low_len, phase;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      mode    = $urandom_range(0, 2);
      run_len = $urandom_range(20, 300);
      period  = $urandom_range(4, 40);
      low_len = $urandom_range(1, period - 1);
      for (phase = 0; phase < run_len; phase++) begin
        @(negedge clk);
        case (mode)
          0:       out_ch.ready = 1'b1;
          1:       out_ch.ready = $urandom_range(0, 1);
          default: out_ch.ready = (phase % period) >= low_len;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    bezout_t exp_res;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: gcd_value %0d", out_ch.gcd_value);
        mismatch_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_ch.gcd_value !== exp_res.gcd_value) begin
          $error("gcd_value: expected %0d, actual %0d", exp_res.gcd_value, out_ch.gcd_value);
          mismatch_count++;
        end
        if (out_ch.coef_first !== exp_res.coef_first) begin
          $error("coef_first: expected %0d, actual %0d", exp_res.coef_first,
                 out_ch.coef_first);
          mismatch_count++;
        end
        if (out_ch.coef_second !== exp_res.coef_second) begin
          $error("coef_second: expected %0d, actual %0d", exp_res.coef_second,
                 out_ch.coef_second);
          mismatch_count++;
        end
        if (out_ch.inverse_value !== exp_res.inverse_value) begin
          $error("inverse_value: expected %0d, actual %0d", exp_res.inverse_value,
                 out_ch.inverse_value);
          mismatch_count++;
        end
        if (out_ch.inverse_valid !== exp_res.inverse_valid) begin
          $error("inverse_valid: expected %0d, actual %0d", exp_res.inverse_valid,
                 out_ch.inverse_valid);
          mismatch_count++;
        end
      end
    end
  end

endmodule
